### design/htl_pkg.sv
// shared types and codes for the hierarchical tree lock table
package htl_pkg;

  localparam int unsigned FuncW   = 2;
  localparam int unsigned IdxW    = 6;
  localparam int unsigned StatusW = 2;

  typedef enum logic [FuncW-1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_LOCK   = 2'd1,
    FUNC_UNLOCK = 2'd2
  } func_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE    = 2'd0,
    ST_REFUSED = 2'd1,
    ST_FULL    = 2'd2,
    ST_BADIDX  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_NODE_CHK,
    S_UP_CHK,
    S_NODE_WR,
    S_ANC_ADJ
  } state_e;

  typedef struct packed {
    logic              done;
    status_e           status;
    logic [IdxW-1:0]   new_node;
  } result_t;

endpackage

### design/htl_ram.sv
// generic single write port ram with registered read
module htl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/htl_seq.sv
// sequencer: add, ancestor check walk and ancestor count update walk
module htl_seq #(
  parameter int unsigned NODE_SLOTS = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            go_i,
  input  htl_pkg::func_e                  func_i,
  input  logic [htl_pkg::IdxW-1:0]        node_i,
  input  logic                            has_parent_i,
  input  logic [htl_pkg::IdxW-1:0]        parent_i,
  output logic                            busy_o,
  output htl_pkg::result_t                result_o,
  output logic                            ram_we_o,
  output logic [$clog2(NODE_SLOTS)-1:0]   ram_waddr_o,
  output logic [2*$clog2(NODE_SLOTS)+1:0] ram_wdata_o,
  output logic [$clog2(NODE_SLOTS)-1:0]   ram_raddr_o,
  input  logic [2*$clog2(NODE_SLOTS)+1:0] ram_rdata_i
);

  localparam int unsigned IW   = $clog2(NODE_SLOTS);
  localparam int unsigned CW   = IW;
  localparam int unsigned CNTW = $clog2(NODE_SLOTS + 1);
  localparam int unsigned WW   = 2 + CW + IW;
  localparam int unsigned XW   = (CNTW > htl_pkg::IdxW) ? CNTW : htl_pkg::IdxW;
  // word layout: lock | locked_below | parent valid | parent index
  localparam int unsigned LockB = WW - 1;
  localparam int unsigned BelTop = WW - 2;
  localparam int unsigned PvB  = IW;

  htl_pkg::state_e state_q, state_d;
  htl_pkg::func_e  func_q;
  logic [htl_pkg::IdxW-1:0] node_q, par_q;
  logic                     hasp_q;
  logic [CNTW-1:0] count_q, count_d;
  logic [WW-1:0]   cur_q, cur_d;
  logic [IW-1:0]   ptr_q, ptr_d;

  logic          rd_lock, rd_pv;
  logic [CW-1:0] rd_below, new_below;
  logic [IW-1:0] rd_par;
  logic          want;

  // shared +1 / -1 unit
  logic [CNTW-1:0] add_a, add_y;
  logic            add_dec;

  logic add_full, add_bad, node_bad, node_refuse;

  assign rd_lock  = ram_rdata_i[LockB];
  assign rd_below = ram_rdata_i[BelTop -: CW];
  assign rd_pv    = ram_rdata_i[PvB];
  assign rd_par   = ram_rdata_i[IW-1:0];
  assign want     = (func_q == htl_pkg::FUNC_LOCK);

  assign add_a   = (state_q == htl_pkg::S_ANC_ADJ) ? CNTW'(rd_below) : count_q;
  assign add_dec = (state_q == htl_pkg::S_ANC_ADJ) && !want;
  assign add_y   = add_dec ? (add_a - CNTW'(1)) : (add_a + CNTW'(1));
  // unlock never takes a count below zero
  assign new_below = (add_dec && (rd_below == '0)) ? '0 : CW'(add_y);

  assign add_full    = (count_q == CNTW'(NODE_SLOTS));
  assign add_bad     = hasp_q && (XW'(par_q) >= XW'(count_q));
  assign node_bad    = (XW'(node_q) >= XW'(count_q));
  assign node_refuse = (rd_lock == want) || (rd_below != '0);

  assign busy_o = (state_q != htl_pkg::S_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      htl_pkg::S_IDLE: begin
        if (go_i) state_d = htl_pkg::S_DECODE;
      end
      htl_pkg::S_DECODE: begin
        if ((func_q == htl_pkg::FUNC_LOCK || func_q == htl_pkg::FUNC_UNLOCK) && !node_bad) begin
          state_d = htl_pkg::S_NODE_CHK;
        end else begin
          state_d = htl_pkg::S_IDLE;
        end
      end
      htl_pkg::S_NODE_CHK: begin
        if (node_refuse) state_d = htl_pkg::S_IDLE;
        else if (rd_pv)  state_d = htl_pkg::S_UP_CHK;
        else             state_d = htl_pkg::S_NODE_WR;
      end
      htl_pkg::S_UP_CHK: begin
        if (rd_lock)     state_d = htl_pkg::S_IDLE;
        else if (!rd_pv) state_d = htl_pkg::S_NODE_WR;
      end
      htl_pkg::S_NODE_WR: begin
        if (cur_q[PvB]) state_d = htl_pkg::S_ANC_ADJ;
        else            state_d = htl_pkg::S_IDLE;
      end
      htl_pkg::S_ANC_ADJ: begin
        if (!rd_pv) state_d = htl_pkg::S_IDLE;
      end
      default: state_d = htl_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    ram_we_o    = 1'b0;
    ram_waddr_o = '0;
    ram_wdata_o = '0;
    ram_raddr_o = ptr_q;
    result_o    = '0;
    count_d     = count_q;
    cur_d       = cur_q;
    ptr_d       = ptr_q;
    case (state_q)
      htl_pkg::S_DECODE: begin
        case (func_q)
          htl_pkg::FUNC_ADD: begin
            result_o.done = 1'b1;
            if (add_full) begin
              result_o.status = htl_pkg::ST_FULL;
            end else if (add_bad) begin
              result_o.status = htl_pkg::ST_BADIDX;
            end else begin
              ram_we_o          = 1'b1;
              ram_waddr_o       = IW'(count_q);
              ram_wdata_o       = {1'b0, {CW{1'b0}}, hasp_q,
                                   hasp_q ? IW'(par_q) : {IW{1'b0}}};
              count_d           = add_y;
              result_o.status   = htl_pkg::ST_DONE;
              result_o.new_node = htl_pkg::IdxW'(count_q);
            end
          end
          htl_pkg::FUNC_LOCK, htl_pkg::FUNC_UNLOCK: begin
            ram_raddr_o = IW'(node_q);
            if (node_bad) begin
              result_o.done   = 1'b1;
              result_o.status = htl_pkg::ST_BADIDX;
            end
          end
          default: begin
            result_o.done   = 1'b1;
            result_o.status = htl_pkg::ST_BADIDX;
          end
        endcase
      end
      htl_pkg::S_NODE_CHK: begin
        cur_d       = ram_rdata_i;
        ram_raddr_o = rd_par;
        if (node_refuse) begin
          result_o.done   = 1'b1;
          result_o.status = htl_pkg::ST_REFUSED;
        end
      end
      htl_pkg::S_UP_CHK: begin
        ram_raddr_o = rd_par;
        if (rd_lock) begin
          result_o.done   = 1'b1;
          result_o.status = htl_pkg::ST_REFUSED;
        end
      end
      htl_pkg::S_NODE_WR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = IW'(node_q);
        ram_wdata_o = {want, cur_q[LockB-1:0]};
        ram_raddr_o = cur_q[IW-1:0];
        ptr_d       = cur_q[IW-1:0];
        if (!cur_q[PvB]) begin
          result_o.done   = 1'b1;
          result_o.status = htl_pkg::ST_DONE;
        end
      end
      htl_pkg::S_ANC_ADJ: begin
        // ptr_q holds the ancestor whose word is on the read port now
        ram_we_o    = 1'b1;
        ram_waddr_o = ptr_q;
        ram_wdata_o = {rd_lock, new_below, rd_pv, rd_par};
        ram_raddr_o = rd_par;
        ptr_d       = rd_par;
        if (!rd_pv) begin
          result_o.done   = 1'b1;
          result_o.status = htl_pkg::ST_DONE;
        end
      end
      default: begin
        ram_raddr_o = ptr_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= htl_pkg::S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i && (state_q == htl_pkg::S_IDLE)) begin
      func_q <= func_i;
      node_q <= node_i;
      hasp_q <= has_parent_i;
      par_q  <= parent_i;
    end
    cur_q <= cur_d;
    ptr_q <= ptr_d;
  end

endmodule

### design/hierarchical_tree_lock_table.sv
// top level of the hierarchical tree lock table
//
// channel   direction  handshake          word
// command   in         start_i / busy_o   func_i node_index_i has_parent_i parent_index_i
// result    out        done_o (1 cycle)   status_o new_node_o
//
// lock and unlock make two ancestor walks (check, then count update), with
// one node table read per step of each walk.
// busy_o is high from the accepted start until the result word is issued.
// reset empties the table at once; no clearing pass is needed.
// done_o is high for exactly one cycle per command and cannot be held off.
module hierarchical_tree_lock_table #(
  parameter int unsigned NODE_SLOTS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [htl_pkg::FuncW-1:0]         func_i,
  input  logic [htl_pkg::IdxW-1:0]          node_index_i,
  input  logic                              has_parent_i,
  input  logic [htl_pkg::IdxW-1:0]          parent_index_i,
  output logic                              done_o,
  output logic [htl_pkg::StatusW-1:0]       status_o,
  output logic [htl_pkg::IdxW-1:0]          new_node_o
);

  localparam int unsigned IW = $clog2(NODE_SLOTS);
  localparam int unsigned WW = 2 + 2 * IW;

  logic             seq_busy;
  logic             go;
  htl_pkg::result_t result;
  logic             ram_we;
  logic [IW-1:0]    ram_waddr, ram_raddr;
  logic [WW-1:0]    ram_wdata, ram_rdata;

  logic                        done_q;
  logic [htl_pkg::StatusW-1:0] status_q;
  logic [htl_pkg::IdxW-1:0]    new_node_q;

  assign go = start_i && !seq_busy;

  htl_seq #(
    .NODE_SLOTS (NODE_SLOTS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .go_i         (go),
    .func_i       (htl_pkg::func_e'(func_i)),
    .node_i       (node_index_i),
    .has_parent_i (has_parent_i),
    .parent_i     (parent_index_i),
    .busy_o       (seq_busy),
    .result_o     (result),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata)
  );

  htl_ram #(
    .WIDTH (WW),
    .DEPTH (NODE_SLOTS)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // result word register, separate from the sequencer so a new command can start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= result.done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result.done) begin
      status_q   <= result.status;
      new_node_q <= result.new_node;
    end
  end

  assign busy_o     = seq_busy;
  assign done_o     = done_q;
  assign status_o   = status_q;
  assign new_node_o = new_node_q;

endmodule
